// ===== rtl/thf_pkg.sv =====
package thf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int THR_W = 15;
	localparam int MINLEN_W = 7;
	localparam int TIME_W = 6;
	localparam int PEAK_W = 15;
	localparam int SUM_W = 21;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W = 1;

	localparam int PACKET_LEN_DEF = 64;

	localparam logic [THR_W-1:0] THRESHOLD_RST = '0;
	localparam logic [MINLEN_W-1:0] MIN_LENGTH_RST = MINLEN_W'(1);
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [TIME_W-1:0] peak_time;
		logic [PEAK_W-1:0] peak_value;
		logic [SUM_W-1:0] sum_value;
		logic hit_continues;
	} hit_t;

endpackage

// ===== rtl/thf_run_tracker.sv =====
module thf_run_tracker #(
	parameter int PACKET_LEN = thf_pkg::PACKET_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic signed [thf_pkg::SAMPLE_W-1:0] sample,
	input logic [thf_pkg::THR_W-1:0] threshold,
	input logic [thf_pkg::MINLEN_W-1:0] min_length,
	output logic hit_valid,
	output thf_pkg::hit_t hit
);

	localparam int POS_W = $clog2(PACKET_LEN);
	localparam int LEN_W = POS_W + 1;
	localparam int CMP_W = (LEN_W > thf_pkg::MINLEN_W) ? LEN_W : thf_pkg::MINLEN_W;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LEN - 1);

	logic [POS_W-1:0] position_q;
	logic in_run_q;
	logic [POS_W-1:0] run_start_q;
	logic [thf_pkg::PEAK_W-1:0] run_peak_q;
	logic [POS_W-1:0] run_peak_pos_q;
	logic [thf_pkg::SUM_W-1:0] run_sum_q;

	logic above;
	logic last;
	logic [thf_pkg::PEAK_W-1:0] v;
	logic [POS_W-1:0] nxt_start;
	logic [thf_pkg::PEAK_W-1:0] nxt_peak;
	logic [POS_W-1:0] nxt_peak_pos;
	logic [thf_pkg::SUM_W-1:0] nxt_sum;
	logic [thf_pkg::SUM_W:0] sum_wide;
	logic [POS_W-1:0] end_pos;
	logic [POS_W-1:0] src_start;
	logic [LEN_W-1:0] run_len;
	logic run_ends;
	logic long_enough;

	assign above = sample > $signed({1'b0, threshold});
	assign last = (position_q == LAST_POS);
	// Only meaningful when above, where the sample lies in 1..32767.
	assign v = sample[thf_pkg::PEAK_W-1:0];

	assign sum_wide = {1'b0, run_sum_q} + (thf_pkg::SUM_W + 1)'(v);

	always_comb begin
		if (!in_run_q) begin
			nxt_start = position_q;
			nxt_peak = v;
			nxt_peak_pos = position_q;
			nxt_sum = thf_pkg::SUM_W'(v);
		end else begin
			nxt_start = run_start_q;
			if (v > run_peak_q) begin
				nxt_peak = v;
				nxt_peak_pos = position_q;
			end else begin
				nxt_peak = run_peak_q;
				nxt_peak_pos = run_peak_pos_q;
			end
			nxt_sum = sum_wide[thf_pkg::SUM_W] ? thf_pkg::SUM_MAX : sum_wide[thf_pkg::SUM_W-1:0];
		end
	end

	// A run ends on the last sample of a packet or on the first sample at or below threshold.
	assign run_ends = (above && last) || (!above && in_run_q);
	assign end_pos = above ? position_q : position_q - POS_W'(1);
	assign src_start = above ? nxt_start : run_start_q;
	assign run_len = LEN_W'(end_pos) - LEN_W'(src_start) + LEN_W'(1);
	assign long_enough = !(CMP_W'(run_len) < CMP_W'(min_length));

	assign hit_valid = run_ends && long_enough;

	always_comb begin
		hit.start_time = thf_pkg::TIME_W'(src_start);
		hit.end_time = thf_pkg::TIME_W'(end_pos);
		hit.peak_time = thf_pkg::TIME_W'(above ? nxt_peak_pos : run_peak_pos_q);
		hit.peak_value = above ? nxt_peak : run_peak_q;
		hit.sum_value = above ? nxt_sum : run_sum_q;
		hit.hit_continues = above && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			in_run_q <= 1'b0;
			run_start_q <= '0;
			run_peak_q <= '0;
			run_peak_pos_q <= '0;
			run_sum_q <= '0;
		end else if (step) begin
			position_q <= last ? '0 : position_q + POS_W'(1);
			in_run_q <= above && !last;
			if (above) begin
				run_start_q <= nxt_start;
				run_peak_q <= nxt_peak;
				run_peak_pos_q <= nxt_peak_pos;
				run_sum_q <= nxt_sum;
			end
		end
	end

endmodule

// ===== rtl/threshold_hit_finder.sv =====
// A sample item is held in the input register; when it ends a run, the run tracker's result
// is loaded into the output register, and a stall there can hold the sample item back.
// Throughput: one sample item per cycle; the input register, the run tracker and the
// output register form a two-stage pipeline that stalls only while a result waits.
// Reset (arst_n low, asynchronous) clears the packet position, the run state and both
// pipeline stages, and sets threshold to 0 and min_length to 1.
module threshold_hit_finder #(
	parameter int PACKET_LEN = thf_pkg::PACKET_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [thf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [thf_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [thf_pkg::SAMPLE_W-1:0] sample,
	output logic out_valid,
	input logic out_ready,
	output logic [thf_pkg::TIME_W-1:0] start_time,
	output logic [thf_pkg::TIME_W-1:0] end_time,
	output logic [thf_pkg::TIME_W-1:0] peak_time,
	output logic [thf_pkg::PEAK_W-1:0] peak_value,
	output logic [thf_pkg::SUM_W-1:0] sum_value,
	output logic hit_continues
);

	logic [thf_pkg::THR_W-1:0] threshold_q;
	logic [thf_pkg::MINLEN_W-1:0] min_length_q;

	logic valid_s1;
	logic signed [thf_pkg::SAMPLE_W-1:0] sample_s1;

	logic out_valid_q;
	thf_pkg::hit_t hit_q;

	logic advance;
	logic step;
	logic hit_valid;
	thf_pkg::hit_t hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= thf_pkg::THRESHOLD_RST;
			min_length_q <= thf_pkg::MIN_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				thf_pkg::REG_THRESHOLD: threshold_q <= cfg_data[thf_pkg::THR_W-1:0];
				thf_pkg::REG_MIN_LENGTH: min_length_q <= cfg_data[thf_pkg::MINLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// The tracker may step unless a finished result is still waiting at the output.
	assign advance = !out_valid_q || out_ready;
	assign step = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
		end
	end

	thf_run_tracker #(
		.PACKET_LEN(PACKET_LEN)
	) u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.sample(sample_s1),
		.threshold(threshold_q),
		.min_length(min_length_q),
		.hit_valid(hit_valid),
		.hit(hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && hit_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && hit_valid) begin
			hit_q <= hit;
		end
	end

	assign out_valid = out_valid_q;
	assign start_time = hit_q.start_time;
	assign end_time = hit_q.end_time;
	assign peak_time = hit_q.peak_time;
	assign peak_value = hit_q.peak_value;
	assign sum_value = hit_q.sum_value;
	assign hit_continues = hit_q.hit_continues;

endmodule

// ===== rtl/thf_checker.sv =====
module thf_checker #(
	parameter int PACKET_LEN = thf_pkg::PACKET_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [thf_pkg::TIME_W-1:0] start_time,
	input logic [thf_pkg::TIME_W-1:0] end_time,
	input logic [thf_pkg::TIME_W-1:0] peak_time,
	input logic [thf_pkg::PEAK_W-1:0] peak_value,
	input logic [thf_pkg::SUM_W-1:0] sum_value,
	input logic hit_continues
);

	localparam logic SHORT_PACKET = (PACKET_LEN <= 64);

	// A stalled result item keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(start_time) && $stable(end_time)
			&& $stable(peak_value) && $stable(sum_value))
		else $error("result item changed while stalled");

	// The sum of a run can never be smaller than its largest sample.
	a_sum_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sum_value >= thf_pkg::SUM_W'(peak_value))
		else $error("sum_value below peak_value");

	// A continuing hit always ends on the last position of the packet.
	a_continue_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_continues |-> end_time == thf_pkg::TIME_W'(PACKET_LEN - 1))
		else $error("continuing hit does not end at the packet end");

	// With positions that fit the time fields, the peak lies inside the run.
	a_peak_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && SHORT_PACKET |-> start_time <= peak_time && peak_time <= end_time)
		else $error("peak_time outside the run");

endmodule

bind threshold_hit_finder thf_checker #(
	.PACKET_LEN(PACKET_LEN)
) u_thf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.start_time(start_time),
	.end_time(end_time),
	.peak_time(peak_time),
	.peak_value(peak_value),
	.sum_value(sum_value),
	.hit_continues(hit_continues)
);
